@@ rtl/core/pvc_pkg.sv @@
// pvc_pkg: shared types, codes and helpers of the prefix-length varint codec
// no dependencies; imported by every module and interface of the block
package pvc_pkg;

   // widths of the item fields
   localparam int VALUE_IN_W  = 64;
   localparam int VALUE_W     = 56;
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 3;

   // longest encoding in bytes, and the 7-bit groups it covers
   localparam int MAX_BYTES   = 8;
   localparam int GROUP_W     = 7;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // result kinds
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_LEAD  = 2'd2;

   // one unit of work for the back end
   typedef struct packed {
      logic                kind;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } job_type;

   // byte idx of a value, zero above the top byte
   function automatic logic [BYTE_W-1:0] byte_at(logic [VALUE_W-1:0] v,
                                                 logic [COUNT_W-1:0] idx);
      logic [BYTE_W*MAX_BYTES-1:0] w;
      w = (BYTE_W*MAX_BYTES)'(v);
      return w[BYTE_W*idx +: BYTE_W];
   endfunction

   // n leading ones of the lead byte
   function automatic logic [BYTE_W-1:0] lead_mask(logic [COUNT_W-1:0] n);
      return ~(8'hFF >> n);
   endfunction

endpackage

@@ rtl/core/pvc_req_if.sv @@
// pvc_req_if: request channel of the varint codec (valid, ready, item fields)
// depends on pvc_pkg for the field widths
interface pvc_req_if;
   import pvc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [VALUE_IN_W-1:0] value_in;
   logic [BYTE_W-1:0]     byte_in;

   modport source (output valid, output opcode, output value_in, output byte_in,
                   input ready);
   modport sink   (input valid, input opcode, input value_in, input byte_in,
                   output ready);
endinterface

@@ rtl/core/pvc_rsp_if.sv @@
// pvc_rsp_if: response channel of the varint codec (valid, ready, result fields)
// depends on pvc_pkg for the field widths
interface pvc_rsp_if;
   import pvc_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   out_byte;
   logic [VALUE_W-1:0]  out_value;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output kind, output out_byte, output out_value,
                   output status, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input out_value,
                   input status, input last, output ready);
endinterface

@@ rtl/core/pvc_front.sv @@
// pvc_front: accepts request transactions, sizes encodes and runs the decoder
// depends on pvc_pkg and pvc_req_if; pushes jobs into pvc_queue
module pvc_front (
   input  logic             clock,
   input  logic             reset,
   pvc_req_if.sink          req,
   input  logic             queue_full,
   output logic             push_valid,
   output pvc_pkg::job_type push_job
);
   import pvc_pkg::*;

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;

   logic               accept;
   logic               too_large;
   logic [COUNT_W-1:0] enc_n;
   logic [COUNT_W:0]   lead_n;
   logic               lead_run;
   logic [VALUE_W-1:0] acc_shift;
   logic [COUNT_W-1:0] rem_dec;
   logic [BYTE_W-1:0]  payload;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   // encode sizing: highest nonzero 7-bit group
   always_comb begin
      too_large = (req.value_in >> (GROUP_W*MAX_BYTES)) != '0;
      enc_n     = '0;
      for (int g = 1; g < MAX_BYTES; g++) begin
         if (req.value_in[GROUP_W*g +: GROUP_W] != '0) begin
            enc_n = COUNT_W'(g);
         end
      end
   end

   // leading ones of a lead byte
   always_comb begin
      lead_n   = '0;
      lead_run = 1'b1;
      for (int b = BYTE_W-1; b >= 0; b--) begin
         if (lead_run && req.byte_in[b]) begin
            lead_n = lead_n + 1'b1;
         end else begin
            lead_run = 1'b0;
         end
      end
   end

   assign payload   = req.byte_in & (8'hFF >> (lead_n + 1'b1));
   assign acc_shift = {acc_ff[VALUE_W-BYTE_W-1:0], req.byte_in};
   assign rem_dec   = rem_ff - 1'b1;

   // classify the transaction and step the decoder
   always_comb begin
      push_job   = '0;
      push_valid = 1'b0;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      if (req.opcode == OP_ENCODE) begin
         push_valid    = 1'b1;
         push_job.kind = KIND_BYTE;
         if (too_large) begin
            push_job.status = ST_TOO_LARGE;
         end else begin
            push_job.value = req.value_in[VALUE_W-1:0];
            push_job.count = enc_n;
         end
      end else if (rem_ff == '0) begin
         if (lead_n >= (COUNT_W+1)'(MAX_BYTES)) begin
            push_valid      = 1'b1;
            push_job.kind   = KIND_VALUE;
            push_job.status = ST_BAD_LEAD;
         end else if (lead_n == '0) begin
            push_valid     = 1'b1;
            push_job.kind  = KIND_VALUE;
            push_job.value = VALUE_W'(payload);
         end else begin
            acc_in = VALUE_W'(payload);
            rem_in = lead_n[COUNT_W-1:0];
         end
      end else begin
         rem_in = rem_dec;
         if (rem_dec == '0) begin
            push_valid     = 1'b1;
            push_job.kind  = KIND_VALUE;
            push_job.value = acc_shift;
            acc_in         = '0;
         end else begin
            acc_in = acc_shift;
         end
      end
      if (!accept) begin
         push_valid = 1'b0;
         acc_in     = acc_ff;
         rem_in     = rem_ff;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

endmodule

@@ rtl/core/pvc_queue.sv @@
// pvc_queue: short first-word-fall-through queue of jobs between front and back
// depends on pvc_pkg
module pvc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  pvc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output pvc_pkg::job_type head
);
   import pvc_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/pvc_back.sv @@
// pvc_back: turns queued jobs into response transactions, one byte per cycle while rsp is not stalled
// depends on pvc_pkg and pvc_rsp_if; pops jobs from pvc_queue
module pvc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  pvc_pkg::job_type head,
   output logic             pop,
   pvc_rsp_if.source        rsp
);
   import pvc_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                kind_ff, kind_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   logic                busy_ff, busy_in;
   logic [VALUE_W-1:0]  cur_value_ff, cur_value_in;
   logic [COUNT_W-1:0]  sel_ff, sel_in;

   logic                load;

   assign load = !rsp_valid_ff || rsp.ready;
   assign pop  = load && !busy_ff && !queue_empty;

   // next response: continue an encode, else start the queue head
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      busy_in      = busy_ff;
      cur_value_in = cur_value_ff;
      sel_in       = sel_ff;
      if (load) begin
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_BYTE;
            byte_in      = byte_at(cur_value_ff, sel_ff);
            value_in     = '0;
            status_in    = ST_OK;
            last_in      = sel_ff == '0;
            busy_in      = sel_ff != '0;
            sel_in       = sel_ff - 1'b1;
         end else if (!queue_empty) begin
            rsp_valid_in = 1'b1;
            kind_in      = head.kind;
            status_in    = head.status;
            byte_in      = '0;
            value_in     = '0;
            last_in      = 1'b1;
            if (head.kind == KIND_VALUE) begin
               value_in = head.value;
            end else if (head.status == ST_OK) begin
               byte_in      = lead_mask(head.count) | byte_at(head.value, head.count);
               last_in      = head.count == '0;
               busy_in      = head.count != '0;
               sel_in       = head.count - 1'b1;
               cur_value_in = head.value;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
      end
   end

   // output and job payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
      cur_value_ff <= cur_value_in;
      sel_ff       <= sel_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = kind_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.out_value = value_ff;
   assign rsp.status    = status_ff;
   assign rsp.last      = last_ff;

endmodule

@@ rtl/core/prefix_varint_codec_core.sv @@
// Prefix-length varint codec, top level.
// Channels: req carries one item per transaction (opcode, value_in, byte_in);
// rsp carries one result per transaction (kind, out_byte, out_value, status,
// last). Both use valid/ready; a transaction happens when both are high.
// Encode: one request gives one to eight byte responses, lead byte first,
// one per cycle if not stalled; 2^56 or more gives a single error response.
// Decode: one stream byte per request; a response is given only when a value
// completes, or for an invalid lead byte 0xFF.
// Jobs are queued; the back end registers each response from the queue head.
// Throughput: one request per cycle while req.ready is high; the back end
// emits one response per cycle unless rsp stalls; no encode is interleaved.
// A four-entry job queue lets requests keep arriving while a response stalls;
// req.ready drops only when that queue is full.
// Reset (synchronous, active high) clears the decoder, the queue, the response
// valid flag and the encode busy flag; no response is pending afterwards.
// When rsp.ready is low the current response holds and the back end waits.
module prefix_varint_codec_core (
   input  logic      clock,
   input  logic      reset,
   pvc_req_if.sink   req,
   pvc_rsp_if.source rsp
);
   import pvc_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   job_type head;

   pvc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   pvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   pvc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule
